>>> sv/mrm_pkg.sv
// Shared types, codes and helpers for the Modbus RTU master transaction engine.
`default_nettype none
package mrm_pkg;

    localparam int READ_BUF_DEPTH_DEF  = 64;
    localparam int WRITE_BUF_DEPTH_DEF = 16;
    localparam int MAX_READ_COUNT_DEF  = 8;

    localparam logic [15:0] TIMEOUT_RST   = 16'd120;
    localparam logic [7:0]  RETRY_RST     = 8'd0;
    localparam logic        DRY_RUN_RST   = 1'b1;
    localparam logic        TRANSPORT_RST = 1'b0;

    localparam logic [1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_RETRY     = 2'd1;
    localparam logic [1:0] REG_DRY_RUN   = 2'd2;
    localparam logic [1:0] REG_TRANSPORT = 2'd3;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] SEL_WRITE    = 2'd0;
    localparam logic [1:0] SEL_RD_HOLD  = 2'd1;
    localparam logic [1:0] SEL_RD_INPUT = 2'd2;

    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_READ_HOLD    = 8'h03;
    localparam logic [7:0] FC_READ_INPUT   = 8'h04;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_RESP  = 3'd1;
    localparam logic [2:0] ST_TIMEOUT   = 3'd2;
    localparam logic [2:0] ST_CRC_ERR   = 3'd3;
    localparam logic [2:0] ST_EXCEPTION = 3'd4;
    localparam logic [2:0] ST_DRY_RUN   = 3'd5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [15:0] crc_body;
        logic [15:0] crc_rx;
    } crc_track_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> sv/mrm_in_if.sv
// Input channel: command beats toward the transaction engine.
`default_nettype none
interface mrm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  slave_addr;
    logic [1:0]  func_sel;
    logic [15:0] reg_addr;
    logic [15:0] value_or_count;
    logic [7:0]  rx_byte;

    modport source (output valid, command, slave_addr, func_sel, reg_addr, value_or_count,
                    rx_byte, input ready);
    modport sink (input valid, command, slave_addr, func_sel, reg_addr, value_or_count,
                  rx_byte, output ready);
endinterface
`default_nettype wire

>>> sv/mrm_out_if.sv
// Output channel: transmit bytes, register values and status beats.
`default_nettype none
interface mrm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] reg_value;
    logic [2:0]  status;
    logic        dry_flag;
    logic        last;

    modport source (output valid, kind, tx_byte, reg_value, status, dry_flag, last,
                    input ready);
    modport sink (input valid, kind, tx_byte, reg_value, status, dry_flag, last,
                  output ready);
endinterface
`default_nettype wire

>>> sv/mrm_resp_store.sv
// Response byte memory with running CRC tracking of the received frame.
`default_nettype none
module mrm_resp_store
    import mrm_pkg::*;
#(
    parameter int DEPTH = READ_BUF_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          clear,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data,
    output crc_track_t         track
);

    logic [7:0]  mem [DEPTH];
    logic [7:0]  rd_data_reg;
    logic [15:0] crc_all_reg, crc_lag1_reg, crc_lag2_reg;
    logic [7:0]  byte_m1_reg, byte_m2_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_all_reg  <= CRC_INIT;
            crc_lag1_reg <= CRC_INIT;
            crc_lag2_reg <= CRC_INIT;
            byte_m1_reg  <= '0;
            byte_m2_reg  <= '0;
        end
        else if (clear)
        begin
            crc_all_reg  <= CRC_INIT;
            crc_lag1_reg <= CRC_INIT;
            crc_lag2_reg <= CRC_INIT;
        end
        else if (wr_en)
        begin
            crc_all_reg  <= crc_byte(crc_all_reg, wr_data);
            crc_lag1_reg <= crc_all_reg;
            crc_lag2_reg <= crc_lag1_reg;
            byte_m1_reg  <= wr_data;
            byte_m2_reg  <= byte_m1_reg;
        end
    end

    // CRC of all but the last two bytes, and the CRC those two bytes carry
    assign track.crc_body = crc_lag2_reg;
    assign track.crc_rx   = {byte_m1_reg, byte_m2_reg};
    assign rd_data        = rd_data_reg;

endmodule
`default_nettype wire

>>> sv/modbus_rtu_master_transaction_top.sv
// Top level of the Modbus RTU master transaction engine with APB register port.
`default_nettype none
// A valid start beat builds an 8-byte request (CRC over six bytes, one byte per cycle) and
// sends it as 8 transmit beats; each following received-byte or tick beat is absorbed
// in S_IDLE (buffer write and running CRC update in the same cycle), and a frame end is
// checked in S_END, after which each register value read back passes S_RVA, S_RVB and
// S_RVC, since each value needs two reads of the single read port of the response memory.
// One beat is in work at a time; results leave through an output register, so the next
// beat is taken while the final result still waits. No clearing pass is needed after reset.
module modbus_rtu_master_transaction_top
    import mrm_pkg::*;
#(
    parameter int READ_BUF_DEPTH  = READ_BUF_DEPTH_DEF,
    parameter int WRITE_BUF_DEPTH = WRITE_BUF_DEPTH_DEF,
    parameter int MAX_READ_COUNT  = MAX_READ_COUNT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    mrm_in_if.sink           in_ch,
    mrm_out_if.source        out_ch
);

    localparam int MEM_DEPTH = (READ_BUF_DEPTH > WRITE_BUF_DEPTH) ? READ_BUF_DEPTH
                                                                   : WRITE_BUF_DEPTH;
    localparam int AW   = $clog2(MEM_DEPTH);
    localparam int LW   = $clog2(MEM_DEPTH + 1);
    localparam int CMPW = 10;

    typedef enum logic [3:0] {
        S_IDLE, S_CRC, S_TX, S_DRYV, S_STAT, S_END, S_RVA, S_RVB, S_RVC
    } state_t;

    typedef enum logic [1:0] {
        TXM_LAST, TXM_DRYW, TXM_DRYR
    } txmode_t;

    // configuration
    logic [15:0] timeout_reg;
    logic [7:0]  retry_reg;
    logic        dry_run_reg;
    logic        transport_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RST;
            retry_reg     <= RETRY_RST;
            dry_run_reg   <= DRY_RUN_RST;
            transport_reg <= TRANSPORT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_TIMEOUT:   timeout_reg   <= pwdata[15:0];
                REG_RETRY:     retry_reg     <= pwdata[7:0];
                REG_DRY_RUN:   dry_run_reg   <= pwdata[0];
                REG_TRANSPORT: transport_reg <= pwdata[0];
                default:       timeout_reg   <= timeout_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_TIMEOUT:   prdata = {16'h0000, timeout_reg};
            REG_RETRY:     prdata = {24'h000000, retry_reg};
            REG_DRY_RUN:   prdata = {31'h0, dry_run_reg};
            REG_TRANSPORT: prdata = {31'h0, transport_reg};
            default:       prdata = '0;
        endcase
    end

    // engine state
    state_t      state_reg, state_next;
    txmode_t     mode_reg, mode_next;
    logic [4:0]  seq_reg, seq_next;
    logic [15:0] crc_reg, crc_next;
    logic [2:0]  stat_reg, stat_next;
    logic        dry_out_reg, dry_out_next;
    logic        busy_reg, busy_next;
    logic [LW-1:0] len_reg, len_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [1:0]  idle_reg, idle_next;
    logic [7:0]  attempts_reg, attempts_next;
    logic        pend_read_reg, pend_read_next;
    logic [4:0]  pend_cnt_reg, pend_cnt_next;
    logic        echo_bad_reg, echo_bad_next;
    logic        hdr_bad_reg, hdr_bad_next;
    logic        exc_reg, exc_next;
    logic [7:0]  hi_reg, hi_next;
    logic [7:0]  req_reg [8];
    logic [7:0]  req_next [8];

    // output register
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [7:0]  out_tx_reg;
    logic [15:0] out_val_reg;
    logic [2:0]  out_stat_reg;
    logic        out_dry_reg;
    logic        out_last_reg;

    logic        emit;
    logic [1:0]  e_kind;
    logic [7:0]  e_tx;
    logic [15:0] e_val;
    logic [2:0]  e_stat;
    logic        e_dry;
    logic        e_last;
    logic        slot;

    logic        mem_clear, mem_wr;
    logic [AW-1:0] mem_raddr;
    logic [7:0]  mem_rdata;
    crc_track_t  track;

    logic [2:0]  req_idx;
    logic [7:0]  req_rd;
    logic [CMPW-1:0] limit_c, min_c, len_c;
    logic        accept;
    logic        bad_req, too_short, crc_bad;
    logic [15:0] crc_step;
    logic [2:0]  fail_code;

    assign slot   = !out_valid_reg || out_ch.ready;
    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);

    assign req_idx = (state_reg == S_IDLE) ? len_reg[2:0] : seq_reg[2:0];
    assign req_rd  = req_reg[req_idx];

    assign limit_c = pend_read_reg ? CMPW'(READ_BUF_DEPTH) : CMPW'(WRITE_BUF_DEPTH);
    assign min_c   = pend_read_reg ? (CMPW'(5) + CMPW'({pend_cnt_reg, 1'b0})) : CMPW'(8);
    assign len_c   = CMPW'(len_reg);

    assign bad_req = (in_ch.func_sel == 2'd3) || (in_ch.slave_addr == 8'h00)
                     || ((in_ch.func_sel != SEL_WRITE)
                         && ((in_ch.value_or_count == 16'h0000)
                             || (in_ch.value_or_count > 16'(MAX_READ_COUNT))));

    assign too_short = len_c < min_c;
    assign crc_bad   = track.crc_body != track.crc_rx;
    assign crc_step  = crc_byte(crc_reg, req_rd);
    assign fail_code = too_short ? ST_TIMEOUT : (crc_bad ? ST_CRC_ERR : ST_EXCEPTION);

    always_comb
    begin
        logic [LW-1:0] len_inc;
        logic [15:0]   el_inc;
        logic [1:0]    idle_inc;
        logic          fin;
        state_next    = state_reg;
        mode_next     = mode_reg;
        seq_next      = seq_reg;
        crc_next      = crc_reg;
        stat_next     = stat_reg;
        dry_out_next  = dry_out_reg;
        busy_next     = busy_reg;
        len_next      = len_reg;
        elapsed_next  = elapsed_reg;
        idle_next     = idle_reg;
        attempts_next = attempts_reg;
        pend_read_next = pend_read_reg;
        pend_cnt_next = pend_cnt_reg;
        echo_bad_next = echo_bad_reg;
        hdr_bad_next  = hdr_bad_reg;
        exc_next      = exc_reg;
        hi_next       = hi_reg;
        req_next      = req_reg;
        emit          = 1'b0;
        e_kind        = KIND_TX;
        e_tx          = '0;
        e_val         = '0;
        e_stat        = ST_OK;
        e_dry         = 1'b0;
        e_last        = 1'b0;
        mem_clear     = 1'b0;
        mem_wr        = 1'b0;
        mem_raddr     = '0;
        len_inc       = len_reg + LW'(1);
        el_inc        = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
        idle_inc      = (idle_reg == 2'd3) ? idle_reg : idle_reg + 2'd1;
        fin           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.command == CMD_START && !busy_reg)
                    begin
                        if (bad_req)
                        begin
                            stat_next    = ST_BAD_RESP;
                            dry_out_next = 1'b0;
                            state_next   = S_STAT;
                        end
                        else
                        begin
                            req_next[0] = in_ch.slave_addr;
                            case (in_ch.func_sel)
                                SEL_WRITE:   req_next[1] = FC_WRITE_SINGLE;
                                SEL_RD_HOLD: req_next[1] = FC_READ_HOLD;
                                default:     req_next[1] = FC_READ_INPUT;
                            endcase
                            req_next[2]    = in_ch.reg_addr[15:8];
                            req_next[3]    = in_ch.reg_addr[7:0];
                            req_next[4]    = in_ch.value_or_count[15:8];
                            req_next[5]    = in_ch.value_or_count[7:0];
                            pend_read_next = (in_ch.func_sel != SEL_WRITE);
                            pend_cnt_next  = (in_ch.func_sel != SEL_WRITE)
                                             ? in_ch.value_or_count[4:0] : 5'd0;
                            seq_next       = '0;
                            crc_next       = CRC_INIT;
                            state_next     = S_CRC;
                        end
                    end
                    else if (in_ch.command == CMD_BYTE && busy_reg)
                    begin
                        idle_next = 2'd0;
                        if (len_c < limit_c)
                        begin
                            mem_wr   = 1'b1;
                            len_next = len_inc;
                            if (len_reg < LW'(6) && in_ch.rx_byte != req_rd)
                            begin
                                echo_bad_next = 1'b1;
                            end
                            if ((len_reg == LW'(0) && in_ch.rx_byte != req_rd)
                                || (len_reg == LW'(1) && in_ch.rx_byte != req_rd)
                                || (len_reg == LW'(2)
                                    && in_ch.rx_byte != {2'b00, pend_cnt_reg, 1'b0}))
                            begin
                                hdr_bad_next = 1'b1;
                            end
                            if (len_reg == LW'(1))
                            begin
                                exc_next = in_ch.rx_byte[7];
                            end
                            if (CMPW'(len_inc) >= limit_c)
                            begin
                                fin = 1'b1;
                            end
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                        if (fin)
                        begin
                            state_next = S_END;
                        end
                    end
                    else if (in_ch.command == CMD_TICK && busy_reg)
                    begin
                        elapsed_next = el_inc;
                        idle_next    = idle_inc;
                        if (el_inc >= timeout_reg || (!too_short && idle_inc == 2'd3))
                        begin
                            state_next = S_END;
                        end
                    end
                end
            end

            S_CRC:
            begin
                crc_next = crc_step;
                seq_next = seq_reg + 5'd1;
                if (seq_reg == 5'd5)
                begin
                    req_next[6] = crc_step[7:0];
                    req_next[7] = crc_step[15:8];
                    seq_next    = '0;
                    if (dry_run_reg)
                    begin
                        mem_clear    = 1'b1;
                        len_next     = '0;
                        elapsed_next = '0;
                        idle_next    = '0;
                        dry_out_next = 1'b1;
                        mode_next    = pend_read_reg ? TXM_DRYR : TXM_DRYW;
                        state_next   = S_TX;
                    end
                    else if (!transport_reg || limit_c < min_c)
                    begin
                        stat_next    = ST_BAD_RESP;
                        dry_out_next = 1'b0;
                        state_next   = S_STAT;
                    end
                    else
                    begin
                        mem_clear     = 1'b1;
                        len_next      = '0;
                        elapsed_next  = '0;
                        idle_next     = '0;
                        echo_bad_next = 1'b0;
                        hdr_bad_next  = 1'b0;
                        attempts_next = '0;
                        busy_next     = 1'b1;
                        dry_out_next  = 1'b0;
                        mode_next     = TXM_LAST;
                        state_next    = S_TX;
                    end
                end
            end

            S_TX:
            begin
                if (slot)
                begin
                    emit     = 1'b1;
                    e_kind   = KIND_TX;
                    e_tx     = req_rd;
                    e_dry    = dry_out_reg;
                    e_last   = (seq_reg == 5'd7) && (mode_reg == TXM_LAST);
                    seq_next = seq_reg + 5'd1;
                    if (seq_reg == 5'd7)
                    begin
                        seq_next = '0;
                        case (mode_reg)
                            TXM_DRYW:
                            begin
                                stat_next  = ST_OK;
                                state_next = S_STAT;
                            end
                            TXM_DRYR:
                            begin
                                state_next = S_DRYV;
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end

            S_DRYV:
            begin
                if (slot)
                begin
                    emit     = 1'b1;
                    e_kind   = KIND_VALUE;
                    e_dry    = 1'b1;
                    seq_next = seq_reg + 5'd1;
                    if (seq_reg == pend_cnt_reg - 5'd1)
                    begin
                        stat_next  = ST_DRY_RUN;
                        state_next = S_STAT;
                    end
                end
            end

            S_STAT:
            begin
                if (slot)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_STATUS;
                    e_stat     = stat_reg;
                    e_dry      = dry_out_reg;
                    e_last     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_END:
            begin
                dry_out_next = 1'b0;
                if (!too_short && !crc_bad && !exc_reg)
                begin
                    busy_next = 1'b0;
                    if (pend_read_reg)
                    begin
                        if (hdr_bad_reg)
                        begin
                            stat_next  = ST_BAD_RESP;
                            state_next = S_STAT;
                        end
                        else
                        begin
                            seq_next   = '0;
                            state_next = S_RVA;
                        end
                    end
                    else
                    begin
                        stat_next  = echo_bad_reg ? ST_BAD_RESP : ST_OK;
                        state_next = S_STAT;
                    end
                end
                else if (attempts_reg < retry_reg)
                begin
                    if (transport_reg)
                    begin
                        attempts_next = attempts_reg + 8'd1;
                        mem_clear     = 1'b1;
                        len_next      = '0;
                        elapsed_next  = '0;
                        idle_next     = '0;
                        echo_bad_next = 1'b0;
                        hdr_bad_next  = 1'b0;
                        seq_next      = '0;
                        mode_next     = TXM_LAST;
                        state_next    = S_TX;
                    end
                    else
                    begin
                        attempts_next = retry_reg;
                        busy_next     = 1'b0;
                        stat_next     = ST_BAD_RESP;
                        state_next    = S_STAT;
                    end
                end
                else
                begin
                    busy_next  = 1'b0;
                    stat_next  = fail_code;
                    state_next = S_STAT;
                end
            end

            S_RVA:
            begin
                mem_raddr  = AW'({seq_reg, 1'b0} + 6'd3);
                state_next = S_RVB;
            end

            S_RVB:
            begin
                mem_raddr  = AW'({seq_reg, 1'b0} + 6'd4);
                hi_next    = mem_rdata;
                state_next = S_RVC;
            end

            S_RVC:
            begin
                mem_raddr = AW'({seq_reg, 1'b0} + 6'd4);
                if (slot)
                begin
                    emit     = 1'b1;
                    e_kind   = KIND_VALUE;
                    e_val    = {hi_reg, mem_rdata};
                    seq_next = seq_reg + 5'd1;
                    if (seq_reg == pend_cnt_reg - 5'd1)
                    begin
                        stat_next  = ST_OK;
                        state_next = S_STAT;
                    end
                    else
                    begin
                        state_next = S_RVA;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= TXM_LAST;
            seq_reg       <= '0;
            stat_reg      <= ST_OK;
            dry_out_reg   <= 1'b0;
            busy_reg      <= 1'b0;
            len_reg       <= '0;
            elapsed_reg   <= '0;
            idle_reg      <= '0;
            attempts_reg  <= '0;
            pend_read_reg <= 1'b0;
            pend_cnt_reg  <= '0;
            echo_bad_reg  <= 1'b0;
            hdr_bad_reg   <= 1'b0;
            exc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            seq_reg       <= seq_next;
            stat_reg      <= stat_next;
            dry_out_reg   <= dry_out_next;
            busy_reg      <= busy_next;
            len_reg       <= len_next;
            elapsed_reg   <= elapsed_next;
            idle_reg      <= idle_next;
            attempts_reg  <= attempts_next;
            pend_read_reg <= pend_read_next;
            pend_cnt_reg  <= pend_cnt_next;
            echo_bad_reg  <= echo_bad_next;
            hdr_bad_reg   <= hdr_bad_next;
            exc_reg       <= exc_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        hi_reg  <= hi_next;
        req_reg <= req_next;
        if (emit)
        begin
            out_kind_reg <= e_kind;
            out_tx_reg   <= e_tx;
            out_val_reg  <= e_val;
            out_stat_reg <= e_stat;
            out_dry_reg  <= e_dry;
            out_last_reg <= e_last;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.kind      = out_kind_reg;
    assign out_ch.tx_byte   = out_tx_reg;
    assign out_ch.reg_value = out_val_reg;
    assign out_ch.status    = out_stat_reg;
    assign out_ch.dry_flag  = out_dry_reg;
    assign out_ch.last      = out_last_reg;

    mrm_resp_store #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (mem_clear),
        .wr_en   (mem_wr),
        .wr_addr (len_reg[AW-1:0]),
        .wr_data (in_ch.rx_byte),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata),
        .track   (track)
    );

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (len_c <= limit_c))
        else $error("response length beyond buffer limit");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.kind == KIND_STATUS) |-> out_ch.last)
        else $error("status beat without last");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> ($stable(out_val_reg) && $stable(out_kind_reg)))
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the Modbus RTU master transaction engine.
`timescale 1ns / 1ps

module testbench;
    import mrm_pkg::*;

    localparam int RD_DEPTH  = 64;
    localparam int WR_DEPTH  = 16;
    localparam int MAX_COUNT = 8;
    localparam int CYCLE_CAP = 3000000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  addr;
        logic [1:0]  sel;
        logic [15:0] regad;
        logic [15:0] val;
        logic [7:0]  rx;
    } beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic [15:0] value;
        logic [2:0]  st;
        logic        dry;
        logic        last;
    } result_t;

    typedef enum int {RSP_GOOD, RSP_BAD_CRC, RSP_EXCEPT, RSP_SHORT, RSP_BAD_HDR, RSP_NOISE}
        rsp_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    mrm_in_if in_ch();
    mrm_out_if out_ch();

    modbus_rtu_master_transaction_top dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always #1 clk = ~clk;

    // transaction engine shadow state
    int unsigned cfg_timeout = 120, cfg_retry = 0, cfg_dry = 1, cfg_transport = 0;
    bit          busy;
    logic [7:0]  req_bytes [8];
    logic [7:0]  rx_buf [RD_DEPTH + WR_DEPTH];
    int unsigned rx_len, ms_elapsed, ms_idle, tries;
    bit          is_read;
    int unsigned read_cnt;

    result_t expected_q[$];
    beat_t   beat_q[$];
    int      errors = 0;
    int      beats_sent = 0;
    int      hold_long = 0;
    int      hold_ask = 0;
    int      hold_seen = 0;
    bit      quiet = 0;

    function automatic logic [15:0] crc16(input logic [7:0] b [RD_DEPTH + WR_DEPTH], input int n);
        logic [15:0] c;
        c = 16'hFFFF;
        for (int i = 0; i < n; i++)
        begin
            c ^= {8'h00, b[i]};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    function automatic int unsigned buf_cap();
        return is_read ? RD_DEPTH : WR_DEPTH;
    endfunction

    function automatic int unsigned frame_min();
        return is_read ? 5 + 2 * read_cnt : 8;
    endfunction

    task automatic push_result(input logic [1:0] k, input logic [7:0] tx, input logic [15:0] v,
                               input logic [2:0] st, input logic dry);
        result_t r;
        r = '{kind: k, tx: tx, value: v, st: st, dry: dry, last: 1'b0};
        expected_q.push_back(r);
    endtask

    task automatic emit_request(input logic dry);
        for (int i = 0; i < 8; i++)
            push_result(KIND_TX, req_bytes[i], 16'h0, ST_OK, dry);
        rx_len = 0;
        ms_elapsed = 0;
        ms_idle = 0;
    endtask

    task automatic close_frame();
        logic [2:0] code;
        logic [15:0] c;
        bit echo_ok;
        if (rx_len < frame_min())
            code = ST_TIMEOUT;
        else
        begin
            c = crc16(rx_buf, rx_len - 2);
            if (c != {rx_buf[rx_len - 1], rx_buf[rx_len - 2]})
                code = ST_CRC_ERR;
            else if (rx_buf[1][7])
                code = ST_EXCEPTION;
            else
                code = ST_OK;
        end
        if (code == ST_OK)
        begin
            busy = 0;
            if (is_read)
            begin
                if (rx_buf[0] != req_bytes[0] || rx_buf[1] != req_bytes[1]
                    || rx_buf[2] != 8'(2 * read_cnt))
                    push_result(KIND_STATUS, 8'h0, 16'h0, ST_BAD_RESP, 1'b0);
                else
                begin
                    for (int i = 0; i < read_cnt; i++)
                        push_result(KIND_VALUE, 8'h0, {rx_buf[3 + 2 * i], rx_buf[4 + 2 * i]},
                                    ST_OK, 1'b0);
                    push_result(KIND_STATUS, 8'h0, 16'h0, ST_OK, 1'b0);
                end
            end
            else
            begin
                echo_ok = 1;
                for (int i = 0; i < 6; i++)
                    if (rx_buf[i] != req_bytes[i])
                        echo_ok = 0;
                push_result(KIND_STATUS, 8'h0, 16'h0, echo_ok ? ST_OK : ST_BAD_RESP, 1'b0);
            end
            return;
        end
        while (tries < cfg_retry)
        begin
            tries++;
            if (cfg_transport != 0)
            begin
                emit_request(1'b0);
                return;
            end
            code = ST_BAD_RESP;
        end
        busy = 0;
        push_result(KIND_STATUS, 8'h0, 16'h0, code, 1'b0);
    endtask

    task automatic begin_request(input beat_t b);
        logic [15:0] c;
        logic [7:0] tmp [RD_DEPTH + WR_DEPTH];
        if (b.sel == 2'd3 || b.addr == 8'h0
            || (b.sel != SEL_WRITE && (b.val == 16'h0 || b.val > MAX_COUNT)))
        begin
            push_result(KIND_STATUS, 8'h0, 16'h0, ST_BAD_RESP, 1'b0);
            return;
        end
        req_bytes[0] = b.addr;
        req_bytes[1] = b.sel == SEL_WRITE ? FC_WRITE_SINGLE
                     : (b.sel == SEL_RD_HOLD ? FC_READ_HOLD : FC_READ_INPUT);
        req_bytes[2] = b.regad[15:8];
        req_bytes[3] = b.regad[7:0];
        req_bytes[4] = b.val[15:8];
        req_bytes[5] = b.val[7:0];
        for (int i = 0; i < 6; i++)
            tmp[i] = req_bytes[i];
        c = crc16(tmp, 6);
        req_bytes[6] = c[7:0];
        req_bytes[7] = c[15:8];
        is_read = b.sel != SEL_WRITE;
        read_cnt = is_read ? b.val[4:0] : 0;
        if (cfg_dry != 0)
        begin
            emit_request(1'b1);
            if (!is_read)
                push_result(KIND_STATUS, 8'h0, 16'h0, ST_OK, 1'b1);
            else
            begin
                for (int i = 0; i < b.val; i++)
                    push_result(KIND_VALUE, 8'h0, 16'h0, ST_OK, 1'b1);
                push_result(KIND_STATUS, 8'h0, 16'h0, ST_DRY_RUN, 1'b1);
            end
            return;
        end
        if (cfg_transport == 0 || buf_cap() < frame_min())
        begin
            push_result(KIND_STATUS, 8'h0, 16'h0, ST_BAD_RESP, 1'b0);
            return;
        end
        tries = 0;
        busy = 1;
        emit_request(1'b0);
    endtask

    task automatic predict(input beat_t b);
        int n0;
        result_t r;
        n0 = expected_q.size();
        if (b.cmd == CMD_START)
        begin
            if (!busy)
                begin_request(b);
        end
        else if (busy && b.cmd == CMD_BYTE)
        begin
            if (rx_len < buf_cap())
            begin
                rx_buf[rx_len] = b.rx;
                rx_len++;
            end
            ms_idle = 0;
            if (rx_len >= buf_cap())
                close_frame();
        end
        else if (busy && b.cmd == CMD_TICK)
        begin
            if (ms_elapsed < 16'hFFFF)
                ms_elapsed++;
            if (ms_idle < 3)
                ms_idle++;
            if (ms_elapsed >= cfg_timeout || (rx_len >= frame_min() && ms_idle >= 3))
                close_frame();
        end
        if (expected_q.size() > n0)
        begin
            r = expected_q.pop_back();
            r.last = 1'b1;
            expected_q.push_back(r);
        end
    endtask

    task automatic offer(input beat_t b);
        while (beat_q.size() > 4)
            @(posedge clk);
        predict(b);
        beat_q.push_back(b);
        beats_sent++;
    endtask

    function automatic beat_t noise_beat(input logic [1:0] cmd);
        beat_t b;
        b = beat_t'($bits(beat_t)'({$urandom, $urandom}));
        b.cmd = cmd;
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] v);
        beat_t b;
        b = noise_beat(CMD_BYTE);
        b.rx = v;
        offer(b);
    endtask

    task automatic send_start(input logic [7:0] a, input logic [1:0] s, input logic [15:0] r,
                              input logic [15:0] v);
        beat_t b;
        b = noise_beat(CMD_START);
        b.addr = a;
        b.sel = s;
        b.regad = r;
        b.val = v;
        offer(b);
    endtask

    task automatic send_reply(input rsp_mode_t mode);
        logic [7:0] f [RD_DEPTH + WR_DEPTH];
        int n;
        logic [15:0] c;
        n = frame_min();
        if (mode == RSP_NOISE)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(20);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom));
            return;
        end
        f[0] = req_bytes[0];
        f[1] = req_bytes[1];
        if (is_read)
        begin
            f[2] = 8'(2 * read_cnt);
            for (int i = 3; i < n - 2; i++)
                f[i] = 8'($urandom);
        end
        else
            for (int i = 2; i < 6; i++)
                f[i] = req_bytes[i];
        if (mode == RSP_EXCEPT)
            f[1] = f[1] | 8'h80;
        if (mode == RSP_BAD_HDR)
        begin
            if ($urandom_range(1) == 0)
                f[0] = f[0] ^ 8'(1 << $urandom_range(7));
            else
                f[is_read ? 2 : 3] = f[is_read ? 2 : 3] ^ 8'h01;
        end
        c = crc16(f, n - 2);
        f[n - 2] = c[7:0];
        f[n - 1] = c[15:8];
        if (mode == RSP_BAD_CRC)
            f[n - 1 - $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
        if (mode == RSP_SHORT)
            n = $urandom_range(n - 1);
        for (int i = 0; i < n; i++)
            send_byte(f[i]);
    endtask

    task automatic run_exchange(input bit good_only);
        logic [1:0] s;
        logic [15:0] v;
        int t0;
        rsp_mode_t mode;
        s = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
        v = (s != SEL_WRITE && $urandom_range(9) != 0) ? 16'($urandom_range(1, MAX_COUNT))
            : 16'($urandom);
        send_start(($urandom_range(19) == 0) ? 8'h0 : 8'($urandom), s, 16'($urandom), v);
        while (busy)
        begin
            t0 = tries;
            mode = good_only ? RSP_GOOD
                 : ($urandom_range(1) == 0 ? RSP_GOOD : rsp_mode_t'($urandom_range(1, 5)));
            send_reply(mode);
            while (busy && tries == t0)
            begin
                if ($urandom_range(15) == 0)
                    offer(noise_beat(CMD_BYTE));
                else
                    offer(noise_beat(CMD_TICK));
            end
        end
        if ($urandom_range(5) == 0)
            offer(noise_beat(2'($urandom_range(3))));
    endtask

    task automatic settle();
        while (beat_q.size() != 0 || in_ch.valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TIMEOUT:   cfg_timeout = v[15:0];
            REG_RETRY:     cfg_retry = v[7:0];
            REG_DRY_RUN:   cfg_dry = v[0];
            REG_TRANSPORT: cfg_transport = v[0];
        endcase
    endtask

    task automatic apply_setting(input int t, input int r, input int d, input int e);
        settle();
        reg_write(REG_TIMEOUT, t);
        reg_write(REG_RETRY, r);
        reg_write(REG_DRY_RUN, d);
        reg_write(REG_TRANSPORT, e);
    endtask

    // sender
    int in_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.command <= '0;
            in_ch.slave_addr <= '0;
            in_ch.func_sel <= '0;
            in_ch.reg_addr <= '0;
            in_ch.value_or_count <= '0;
            in_ch.rx_byte <= '0;
        end
        else if (in_ch.valid && !in_ch.ready)
        begin
        end
        else if (in_gap > 0)
        begin
            in_ch.valid <= 1'b0;
            in_gap <= in_gap - 1;
        end
        else if (beat_q.size() != 0)
        begin
            beat_t b;
            b = beat_q.pop_front();
            in_ch.valid <= 1'b1;
            in_ch.command <= b.cmd;
            in_ch.slave_addr <= b.addr;
            in_ch.func_sel <= b.sel;
            in_ch.reg_addr <= b.regad;
            in_ch.value_or_count <= b.val;
            in_ch.rx_byte <= b.rx;
            if (!quiet)
                case ($urandom_range(19))
                    0, 1, 2, 3: in_gap <= $urandom_range(1, 3);
                    4:          in_gap <= $urandom_range(10, 40);
                    default:    in_gap <= 0;
                endcase
        end
        else
            in_ch.valid <= 1'b0;
    end

    // receiver and checker
    int out_stall = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                result_t got, want;
                got = '{kind: out_ch.kind, tx: out_ch.tx_byte, value: out_ch.reg_value,
                        st: out_ch.status, dry: out_ch.dry_flag, last: out_ch.last};
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat %p", $time, got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: result mismatch expected %p actual %p", $time, want, got);
                    end
                end
            end
            if (hold_ask != hold_seen)
            begin
                out_ch.ready <= 1'b0;
                hold_long <= 400;
                hold_seen <= hold_ask;
            end
            else if (hold_long > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_long <= hold_long - 1;
            end
            else if (out_stall > 0)
            begin
                out_ch.ready <= 1'b0;
                out_stall <= out_stall - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!quiet)
                    case ($urandom_range(19))
                        0, 1, 2: out_stall <= $urandom_range(1, 3);
                        3:       out_stall <= $urandom_range(8, 30);
                        default: out_stall <= 0;
                    endcase
            end
        end
    end

    int cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("modbus_rtu_master_transaction_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // dry run from reset: frame extremes, both reads, rejects, stray beats
        send_start(8'hFF, SEL_WRITE, 16'hFFFF, 16'hFFFF);
        send_start(8'h01, SEL_RD_HOLD, 16'h0000, 16'd8);
        send_start(8'h80, SEL_RD_INPUT, 16'h1234, 16'd1);
        send_start(8'h00, SEL_WRITE, 16'h0001, 16'h0001);
        send_start(8'h11, 2'd3, 16'h0001, 16'h0001);
        send_start(8'h11, SEL_RD_HOLD, 16'h0001, 16'd0);
        send_start(8'h11, SEL_RD_INPUT, 16'h0001, 16'd9);
        send_start(8'h11, SEL_RD_HOLD, 16'h0001, 16'hFFFF);
        offer(noise_beat(CMD_BYTE));
        offer(noise_beat(CMD_TICK));
        offer(noise_beat(2'd3));

        apply_setting(10, 2, 0, 1);
        for (int m = RSP_GOOD; m <= RSP_NOISE; m++)
        begin
            send_start(8'h05, SEL_RD_HOLD, 16'h0010, 16'd2);
            send_reply(rsp_mode_t'(m));
            while (busy)
                offer(noise_beat(CMD_TICK));
        end
        send_start(8'h07, SEL_WRITE, 16'hBEEF, 16'h00AA);
        send_start(8'h08, SEL_WRITE, 16'h0000, 16'h0000);
        send_reply(RSP_GOOD);
        while (busy)
            offer(noise_beat(CMD_TICK));

        hold_ask = hold_ask + 1;
        repeat (3) run_exchange(0);
        settle();

        apply_setting(0, 1, 0, 1);
        repeat (2) run_exchange(0);
        apply_setting(65535, 0, 0, 1);
        quiet = 1;
        repeat (2) run_exchange(1);
        quiet = 0;
        apply_setting(5, 255, 0, 1);
        repeat (1) run_exchange(0);
        apply_setting(20, 3, 0, 0);
        repeat (3) run_exchange(0);
        apply_setting(15, 1, 1, 1);
        repeat (3) run_exchange(0);
        apply_setting(12, 2, 0, 1);
        while (beats_sent < 350)
            run_exchange(0);

        settle();
        if (errors == 0)
            $display("modbus_rtu_master_transaction_top: match");
        else
            $display("modbus_rtu_master_transaction_top: mismatch");
        $finish;
    end

endmodule
